FILE: rtl/bbpmc_pkg.sv
// shared constants and types for the bayer defect pixel median corrector
// no dependencies
`timescale 1ns / 1ps

package bbpmc_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int NUM_BANKS = 8;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int BANK_W = $clog2(NUM_BANKS);
  localparam int WID_W = 13;
  localparam int ROW_W = 16;
  localparam int PIX_W = 8;
  localparam int FL_W = COL_W + 2;
  localparam int CRED_W = COL_W + 4;
  localparam int CFG_W = 16;

  localparam logic [PIX_W-1:0] THR_RESET = 8'd245;
  localparam logic [WID_W-1:0] WIDTH_RESET = 13'd1920;
  localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd1080;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] dn;
  } col_t;

  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] mi;
    logic [PIX_W-1:0] hi;
  } trip_t;

  typedef struct packed {
    logic              emit;
    logic              tail;
    logic              lrep;
    logic              eol;
    logic              eof;
    logic [BANK_W-1:0] bank_up;
    logic [BANK_W-1:0] bank_mid;
    logic [BANK_W-1:0] bank_dn;
  } meta_t;

endpackage

FILE: rtl/bayer_bad_pixel_median_correct_core.sv
// bayer defect pixel correction with a 3x3 same-color median
// depends on bbpmc_pkg
// throughput: one input word and one output word per cycle, set by the
//   single read port of each of the eight line banks, while in_ready_o
//   and out_ready_i hold no stall
// reset: counters and handshake clear at once, config registers take reset values,
//   line banks are not cleared and no clearing pass runs
`timescale 1ns / 1ps

module bayer_bad_pixel_median_correct_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_index_i,
  input  logic [bbpmc_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             command_i,
  input  logic [bbpmc_pkg::PIX_W-1:0]      pixel_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bbpmc_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                             was_corrected_o,
  output logic                             end_of_line_o,
  output logic                             end_of_frame_o
);

  localparam int COL_W = bbpmc_pkg::COL_W;
  localparam int ROW_W = bbpmc_pkg::ROW_W;
  localparam int WID_W = bbpmc_pkg::WID_W;
  localparam int PIX_W = bbpmc_pkg::PIX_W;
  localparam int FL_W = bbpmc_pkg::FL_W;
  localparam int CRED_W = bbpmc_pkg::CRED_W;
  localparam int BANK_W = bbpmc_pkg::BANK_W;
  localparam int NUM_BANKS = bbpmc_pkg::NUM_BANKS;
  localparam int MAX_WIDTH = bbpmc_pkg::MAX_WIDTH;

  function automatic bbpmc_pkg::trip_t sort3(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] x, y, z, t;
    bbpmc_pkg::trip_t r;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    r.lo = x;
    r.mi = y;
    r.hi = z;
    return r;
  endfunction

  // configuration
  logic [PIX_W-1:0] thr_q;
  logic [WID_W-1:0] width_q;
  logic [ROW_W-1:0] height_q;
  logic             restart;

  assign restart = cfg_we_i && ((cfg_index_i == bbpmc_pkg::REG_WIDTH) ||
                                (cfg_index_i == bbpmc_pkg::REG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= bbpmc_pkg::THR_RESET;
      width_q  <= bbpmc_pkg::WIDTH_RESET;
      height_q <= bbpmc_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bbpmc_pkg::REG_THRESHOLD: thr_q    <= cfg_wdata_i[PIX_W-1:0];
        bbpmc_pkg::REG_WIDTH:     width_q  <= cfg_wdata_i[WID_W-1:0];
        bbpmc_pkg::REG_HEIGHT:    height_q <= cfg_wdata_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [WID_W-1:0] w_eff;
  logic [WID_W-1:0] w_sat;
  logic [COL_W-1:0] wl;
  logic [ROW_W-1:0] h_eff;
  logic [ROW_W-1:0] h_sat;
  logic [FL_W-1:0]  fl_last;

  always_comb begin
    if (width_q > WID_W'(MAX_WIDTH)) begin
      w_sat = WID_W'(MAX_WIDTH);
    end else if (width_q < WID_W'(4)) begin
      w_sat = WID_W'(4);
    end else begin
      w_sat = width_q;
    end
    w_eff = {w_sat[WID_W-1:1], 1'b0};
    h_sat = (height_q < ROW_W'(4)) ? ROW_W'(4) : height_q;
    h_eff = {h_sat[ROW_W-1:1], 1'b0};
  end

  assign wl      = COL_W'(w_eff - WID_W'(1));
  assign fl_last = {w_eff, 1'b1};

  // input side and release bookkeeping
  logic [ROW_W-1:0]  in_row_q, in_row_d;
  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [FL_W-1:0]   fl_q, fl_d;
  logic [CRED_W-1:0] cred_q, cred_d;
  logic              wait_q, wait_d;
  logic              in_acc;
  logic              frame_in;
  logic              wr_en;
  logic              m_emit;

  // output side slot counters
  logic [ROW_W-1:0]  gen_row_q, gen_row_d;
  logic [COL_W-1:0]  gen_col_q, gen_col_d;
  logic              g_read_row;
  logic [ROW_W-1:0]  row_up, row_dn;
  logic              avail;
  logic              g_emit;
  logic              g_tail;
  logic              issue;
  logic              gen_wrap;
  logic              adv;

  assign frame_in = in_row_q < h_eff;
  assign in_ready_o = !wait_q && (!frame_in ||
      ({1'b0, in_row_q} < ({1'b0, gen_row_q} + (ROW_W + 1)'(6))));
  assign in_acc = in_valid_i && in_ready_o;
  assign wr_en = in_acc && frame_in && (command_i == bbpmc_pkg::CMD_PIXEL);

  always_comb begin
    m_emit = 1'b0;
    if (in_acc) begin
      if (frame_in) begin
        m_emit = (command_i == bbpmc_pkg::CMD_PIXEL) &&
                 ((in_row_q >= ROW_W'(3)) ||
                  ((in_row_q == ROW_W'(2)) && (in_col_q >= COL_W'(2))));
      end else begin
        m_emit = 1'b1;
      end
    end
  end

  assign g_read_row = gen_row_q < h_eff;
  assign row_up = (gen_row_q < ROW_W'(2)) ? gen_row_q : gen_row_q - ROW_W'(2);
  assign row_dn = (gen_row_q >= h_eff - ROW_W'(2)) ? gen_row_q : gen_row_q + ROW_W'(2);
  assign avail = !g_read_row || wait_q || (in_row_q > row_dn) ||
                 ((in_row_q == row_dn) && (in_col_q > gen_col_q));
  assign g_emit = (gen_col_q >= COL_W'(2)) || (gen_row_q != '0);
  assign g_tail = (gen_col_q < COL_W'(2)) && (gen_row_q != '0);
  assign issue = adv && avail && (!g_emit || (cred_q != '0));
  assign gen_wrap = issue && !g_read_row && (gen_col_q == COL_W'(1));

  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    fl_d      = fl_q;
    wait_d    = wait_q;
    gen_row_d = gen_row_q;
    gen_col_d = gen_col_q;
    cred_d    = cred_q + CRED_W'(m_emit) - CRED_W'(issue && g_emit);
    if (restart) begin
      in_row_d  = '0;
      in_col_d  = '0;
      fl_d      = '0;
      wait_d    = 1'b0;
      gen_row_d = '0;
      gen_col_d = '0;
      cred_d    = '0;
    end else begin
      if (in_acc) begin
        if (frame_in) begin
          if (command_i == bbpmc_pkg::CMD_PIXEL) begin
            if (in_col_q == wl) begin
              in_col_d = '0;
              in_row_d = in_row_q + ROW_W'(1);
            end else begin
              in_col_d = in_col_q + COL_W'(1);
            end
          end
        end else if (fl_q == fl_last) begin
          in_row_d = '0;
          in_col_d = '0;
          fl_d     = '0;
          wait_d   = 1'b1;
        end else begin
          fl_d = fl_q + FL_W'(1);
        end
      end
      if (issue) begin
        if (gen_wrap) begin
          gen_row_d = '0;
          gen_col_d = '0;
          wait_d    = 1'b0;
        end else if (g_read_row && (gen_col_q == wl)) begin
          gen_col_d = '0;
          gen_row_d = gen_row_q + ROW_W'(1);
        end else begin
          gen_col_d = gen_col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      fl_q      <= '0;
      wait_q    <= 1'b0;
      gen_row_q <= '0;
      gen_col_q <= '0;
      cred_q    <= '0;
    end else begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      fl_q      <= fl_d;
      wait_q    <= wait_d;
      gen_row_q <= gen_row_d;
      gen_col_q <= gen_col_d;
      cred_q    <= cred_d;
    end
  end

  // line banks, one per row modulo eight
  logic [PIX_W-1:0] rd_q [NUM_BANKS];

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_WIDTH];

    always_ff @(posedge clk_i) begin
      if (wr_en && (in_row_q[BANK_W-1:0] == BANK_W'(b))) begin
        mem[in_col_q] <= pixel_in_i;
      end
      if (issue) begin
        rd_q[b] <= mem[gen_col_q];
      end
    end
  end

  // pipeline
  bbpmc_pkg::meta_t s1_m, s2_m, s3_m, s4_m, s0_m;
  logic             s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  bbpmc_pkg::col_t  [4:0] win_q;
  bbpmc_pkg::col_t  new_col;
  bbpmc_pkg::col_t  cl, cc, cr;
  bbpmc_pkg::trip_t s3_up_q, s3_mid_q, s3_dn_q;
  logic [PIX_W-1:0] s3_ctr_q;
  logic [PIX_W-1:0] lo_max, hi_min;
  bbpmc_pkg::trip_t mid_s, fin_s, lo_s, hi_s;
  logic [PIX_W-1:0] s4_med_q, s4_ctr_q;
  logic [PIX_W-1:0] diff;
  logic             out_valid_q;

  assign adv = !out_valid_q || out_ready_i;

  always_comb begin
    s0_m.emit     = g_emit;
    s0_m.tail     = g_tail;
    s0_m.lrep     = !g_tail && (gen_col_q < COL_W'(4));
    s0_m.eol      = g_tail && (gen_col_q == COL_W'(1));
    s0_m.eof      = g_tail && (gen_col_q == COL_W'(1)) && !g_read_row;
    s0_m.bank_up  = row_up[BANK_W-1:0];
    s0_m.bank_mid = gen_row_q[BANK_W-1:0];
    s0_m.bank_dn  = row_dn[BANK_W-1:0];
  end

  assign new_col.up  = rd_q[s1_m.bank_up];
  assign new_col.mid = rd_q[s1_m.bank_mid];
  assign new_col.dn  = rd_q[s1_m.bank_dn];

  always_comb begin
    cc = win_q[2];
    cl = s2_m.lrep ? win_q[2] : win_q[4];
    cr = s2_m.tail ? win_q[2] : win_q[0];
  end

  always_comb begin
    lo_s   = sort3(s3_up_q.lo, s3_mid_q.lo, s3_dn_q.lo);
    hi_s   = sort3(s3_up_q.hi, s3_mid_q.hi, s3_dn_q.hi);
    mid_s  = sort3(s3_up_q.mi, s3_mid_q.mi, s3_dn_q.mi);
    lo_max = lo_s.hi;
    hi_min = hi_s.lo;
    fin_s  = sort3(lo_max, mid_s.mi, hi_min);
  end

  assign diff = (s4_ctr_q > s4_med_q) ? s4_ctr_q - s4_med_q : s4_med_q - s4_ctr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (restart) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= issue;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      out_valid_q <= s4_v_q && s4_m.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_m <= s0_m;
      s2_m <= s1_m;
      if (s1_v_q) begin
        win_q <= {win_q[3:0], new_col};
      end
      s3_m     <= s2_m;
      s3_up_q  <= sort3(cl.up, cc.up, cr.up);
      s3_mid_q <= sort3(cl.mid, cc.mid, cr.mid);
      s3_dn_q  <= sort3(cl.dn, cc.dn, cr.dn);
      s3_ctr_q <= cc.mid;
      s4_m     <= s3_m;
      s4_med_q <= fin_s.mi;
      s4_ctr_q <= s3_ctr_q;
      if (diff > thr_q) begin
        pixel_out_o     <= s4_med_q;
        was_corrected_o <= 1'b1;
      end else begin
        pixel_out_o     <= s4_ctr_q;
        was_corrected_o <= 1'b0;
      end
      end_of_line_o  <= s4_m.eol;
      end_of_frame_o <= s4_m.eof;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
